@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, off during reset.
`define CHECK_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");

// Implication checked in the next cycle, off during reset.
`define CHECK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");

// Implication that also holds through reset.
`define CHECK_ALWAYS(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |-> (c)) \
    else $error("check failed");

`endif

@@ rtl/ofcw_pkg.sv @@
`timescale 1ns / 1ps
package ofcw_pkg;

  localparam int FLOW_BITS = 16;
  localparam int SCALE_BITS = 24;
  localparam int XW = 51;
  localparam int TURN_BITS = 24;
  localparam int STEPS = 22;
  localparam int RAD_BITS = 22;
  localparam int REM_BITS = 43;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 24'd65536;

  typedef struct packed {
    logic signed [FLOW_BITS-1:0] flow_x;
    logic signed [FLOW_BITS-1:0] flow_y;
    logic frame_last_in;
  } flow_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic frame_last_out;
  } pixel_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [TURN_BITS-1:0] z;
    logic fixed;
    logic [REM_BITS-1:0] rem;
    logic [RAD_BITS-1:0] res;
    logic inner;
    logic last;
  } cell_t;

  function automatic logic [TURN_BITS-1:0] arc(input int i);
    logic [TURN_BITS-1:0] a;
    case (i)
      0: a = 24'd2097152;
      1: a = 24'd1238021;
      2: a = 24'd654136;
      3: a = 24'd332050;
      4: a = 24'd166669;
      5: a = 24'd83416;
      6: a = 24'd41718;
      7: a = 24'd20860;
      8: a = 24'd10430;
      9: a = 24'd5215;
      10: a = 24'd2608;
      11: a = 24'd1304;
      12: a = 24'd652;
      13: a = 24'd326;
      14: a = 24'd163;
      15: a = 24'd81;
      16: a = 24'd41;
      17: a = 24'd20;
      18: a = 24'd10;
      19: a = 24'd5;
      20: a = 24'd3;
      21: a = 24'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Wheel entry as {red, green, blue}.
  function automatic logic [23:0] wheel(input logic [5:0] k);
    logic [23:0] c;
    case (k)
      6'd0: c = {8'd255, 8'd0, 8'd0};
      6'd1: c = {8'd255, 8'd17, 8'd0};
      6'd2: c = {8'd255, 8'd34, 8'd0};
      6'd3: c = {8'd255, 8'd51, 8'd0};
      6'd4: c = {8'd255, 8'd68, 8'd0};
      6'd5: c = {8'd255, 8'd85, 8'd0};
      6'd6: c = {8'd255, 8'd102, 8'd0};
      6'd7: c = {8'd255, 8'd119, 8'd0};
      6'd8: c = {8'd255, 8'd136, 8'd0};
      6'd9: c = {8'd255, 8'd153, 8'd0};
      6'd10: c = {8'd255, 8'd170, 8'd0};
      6'd11: c = {8'd255, 8'd187, 8'd0};
      6'd12: c = {8'd255, 8'd204, 8'd0};
      6'd13: c = {8'd255, 8'd221, 8'd0};
      6'd14: c = {8'd255, 8'd238, 8'd0};
      6'd15: c = {8'd255, 8'd255, 8'd0};
      6'd16: c = {8'd213, 8'd255, 8'd0};
      6'd17: c = {8'd170, 8'd255, 8'd0};
      6'd18: c = {8'd128, 8'd255, 8'd0};
      6'd19: c = {8'd85, 8'd255, 8'd0};
      6'd20: c = {8'd43, 8'd255, 8'd0};
      6'd21: c = {8'd0, 8'd255, 8'd0};
      6'd22: c = {8'd0, 8'd255, 8'd63};
      6'd23: c = {8'd0, 8'd255, 8'd127};
      6'd24: c = {8'd0, 8'd255, 8'd191};
      6'd25: c = {8'd0, 8'd255, 8'd255};
      6'd26: c = {8'd0, 8'd232, 8'd255};
      6'd27: c = {8'd0, 8'd209, 8'd255};
      6'd28: c = {8'd0, 8'd186, 8'd255};
      6'd29: c = {8'd0, 8'd163, 8'd255};
      6'd30: c = {8'd0, 8'd140, 8'd255};
      6'd31: c = {8'd0, 8'd116, 8'd255};
      6'd32: c = {8'd0, 8'd93, 8'd255};
      6'd33: c = {8'd0, 8'd70, 8'd255};
      6'd34: c = {8'd0, 8'd47, 8'd255};
      6'd35: c = {8'd0, 8'd24, 8'd255};
      6'd36: c = {8'd0, 8'd0, 8'd255};
      6'd37: c = {8'd19, 8'd0, 8'd255};
      6'd38: c = {8'd39, 8'd0, 8'd255};
      6'd39: c = {8'd58, 8'd0, 8'd255};
      6'd40: c = {8'd78, 8'd0, 8'd255};
      6'd41: c = {8'd98, 8'd0, 8'd255};
      6'd42: c = {8'd117, 8'd0, 8'd255};
      6'd43: c = {8'd137, 8'd0, 8'd255};
      6'd44: c = {8'd156, 8'd0, 8'd255};
      6'd45: c = {8'd176, 8'd0, 8'd255};
      6'd46: c = {8'd196, 8'd0, 8'd255};
      6'd47: c = {8'd215, 8'd0, 8'd255};
      6'd48: c = {8'd235, 8'd0, 8'd255};
      6'd49: c = {8'd255, 8'd0, 8'd255};
      6'd50: c = {8'd255, 8'd0, 8'd213};
      6'd51: c = {8'd255, 8'd0, 8'd170};
      6'd52: c = {8'd255, 8'd0, 8'd128};
      6'd53: c = {8'd255, 8'd0, 8'd85};
      6'd54: c = {8'd255, 8'd0, 8'd43};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/optical_flow_color_wheel.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Flow vector to color converter.
// Input channel: flow_valid, flow_stall and flow carry one flow vector per
// transfer, with its end-of-frame mark. Output channel: pixel_valid,
// pixel_stall and pixel carry the RGB color and the copied mark.
// scale_we and scale_data write the inverse scale register; write it only
// while no pixel is in flight.
// One vector is taken every clock cycle while flow_stall is low. Each vector
// passes through registered stages of scaling and squaring, a chain of 22
// cells that each do one angle rotation and one square root bit, and
// registered stages of wheel lookup, blending and fading.
// When the receiver stalls, results pile up in the pipeline stages and the
// input keeps being taken until every stage holds an item; then flow_stall
// rises. Synchronous reset empties the pipeline and sets the inverse scale
// back to 1.0.
module optical_flow_color_wheel (
  input  logic clk,
  input  logic rst,
  input  logic flow_valid,
  output logic flow_stall,
  input  ofcw_pkg::flow_t flow,
  input  logic scale_we,
  input  logic [ofcw_pkg::SCALE_BITS-1:0] scale_data,
  output logic pixel_valid,
  input  logic pixel_stall,
  output ofcw_pkg::pixel_t pixel
);

  localparam int N = ofcw_pkg::STEPS;

  logic chain_valid [N+1];
  logic chain_ready [N+1];
  ofcw_pkg::cell_t chain_data [N+1];

  ofcw_front u_front (
    .clk(clk),
    .rst(rst),
    .flow_valid(flow_valid),
    .flow_stall(flow_stall),
    .flow(flow),
    .scale_we(scale_we),
    .scale_data(scale_data),
    .out_valid(chain_valid[0]),
    .out_ready(chain_ready[0]),
    .out_data(chain_data[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    ofcw_cell #(.STEP(i)) u_cell (
      .clk(clk),
      .rst(rst),
      .in_valid(chain_valid[i]),
      .in_ready(chain_ready[i]),
      .in_data(chain_data[i]),
      .out_valid(chain_valid[i+1]),
      .out_ready(chain_ready[i+1]),
      .out_data(chain_data[i+1])
    );
  end

  ofcw_back u_back (
    .clk(clk),
    .rst(rst),
    .in_valid(chain_valid[N]),
    .in_ready(chain_ready[N]),
    .in_data(chain_data[N]),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel(pixel)
  );

  `CHECK_NOW(empty_output_never_stalls, clk, rst, !pixel_valid, !flow_stall)
  `CHECK_ALWAYS(no_result_after_reset, clk, $past(rst), !pixel_valid)

endmodule

@@ rtl/ofcw_front.sv @@
`timescale 1ns / 1ps
module ofcw_front (
  input  logic clk,
  input  logic rst,
  input  logic flow_valid,
  output logic flow_stall,
  input  ofcw_pkg::flow_t flow,
  input  logic scale_we,
  input  logic [ofcw_pkg::SCALE_BITS-1:0] scale_data,
  output logic out_valid,
  input  logic out_ready,
  output ofcw_pkg::cell_t out_data
);

  localparam int FB = ofcw_pkg::FLOW_BITS;
  localparam int XW = ofcw_pkg::XW;
  localparam int SH = 48 - FB;
  localparam int AW = FB + ofcw_pkg::SCALE_BITS;
  localparam logic [ofcw_pkg::TURN_BITS-1:0] HALF = 24'h800000;
  localparam logic [ofcw_pkg::TURN_BITS-1:0] QUARTER = 24'h400000;
  localparam logic [ofcw_pkg::TURN_BITS-1:0] THREE_Q = 24'hC00000;

  logic [ofcw_pkg::SCALE_BITS-1:0] scale;
  logic [3:0] v;
  logic en0, en1, en2, en3;

  logic signed [FB-1:0] x0, y0, x1, y1, x2, y2;
  logic last0, last1, last2;
  logic [AW-1:0] ax1, ay1;
  logic small2;
  logic [43:0] sx2, sy2;
  logic [FB-1:0] abs_x, abs_y;
  logic [44:0] sum;
  logic signed [XW-1:0] xs, ys;
  ofcw_pkg::cell_t init, stage3;

  assign en3 = !v[3] || out_ready;
  assign en2 = !v[2] || en3;
  assign en1 = !v[1] || en2;
  assign en0 = !v[0] || en1;
  assign flow_stall = !en0;
  assign out_valid = v[3];
  assign out_data = stage3;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= ofcw_pkg::SCALE_RESET;
    end else if (scale_we) begin
      scale <= scale_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en0) v[0] <= flow_valid;
      if (en1) v[1] <= v[0];
      if (en2) v[2] <= v[1];
      if (en3) v[3] <= v[2];
    end
  end

  assign abs_x = x0[FB-1] ? (~x0 + 1'b1) : x0;
  assign abs_y = y0[FB-1] ? (~y0 + 1'b1) : y0;
  assign sum = {1'b0, sx2} + {1'b0, sy2};
  assign xs = {{(XW-FB){x2[FB-1]}}, x2} <<< SH;
  assign ys = {{(XW-FB){y2[FB-1]}}, y2} <<< SH;

  always_comb begin
    init = '0;
    init.last = last2;
    init.inner = small2 && (sum <= (45'd1 << 42));
    init.rem = init.inner ? sum[ofcw_pkg::REM_BITS-1:0] : '0;
    init.res = '0;
    init.fixed = 1'b1;
    init.x = xs;
    init.y = ys;
    init.z = '0;
    if (x2 == '0 && y2 == '0) begin
      init.z = '0;
    end else if (y2 == '0) begin
      init.z = x2[FB-1] ? HALF : '0;
    end else if (x2 == '0) begin
      init.z = y2[FB-1] ? THREE_Q : QUARTER;
    end else begin
      init.fixed = 1'b0;
      if (x2[FB-1]) begin
        init.x = -xs;
        init.y = -ys;
        init.z = HALF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      x0 <= flow.flow_x;
      y0 <= flow.flow_y;
      last0 <= flow.frame_last_in;
    end
    if (en1) begin
      x1 <= x0;
      y1 <= y0;
      last1 <= last0;
      ax1 <= AW'(abs_x) * AW'(scale);
      ay1 <= AW'(abs_y) * AW'(scale);
    end
    if (en2) begin
      x2 <= x1;
      y2 <= y1;
      last2 <= last1;
      small2 <= (ax1 <= AW'(1 << 21)) && (ay1 <= AW'(1 << 21));
      sx2 <= 44'(ax1[21:0]) * 44'(ax1[21:0]);
      sy2 <= 44'(ay1[21:0]) * 44'(ay1[21:0]);
    end
    if (en3) begin
      stage3 <= init;
    end
  end

endmodule

@@ rtl/ofcw_cell.sv @@
`timescale 1ns / 1ps
module ofcw_cell #(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  ofcw_pkg::cell_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output ofcw_pkg::cell_t out_data
);

  localparam int B = ofcw_pkg::RAD_BITS - 1 - STEP;

  logic v;
  logic en;
  ofcw_pkg::cell_t data, nxt;
  logic signed [ofcw_pkg::XW-1:0] dx, dy;
  logic [43:0] test;

  assign en = !v || out_ready;
  assign in_ready = en;
  assign out_valid = v;
  assign out_data = data;

  assign dx = in_data.y >>> STEP;
  assign dy = in_data.x >>> STEP;
  assign test = ({22'd0, in_data.res} << (B + 1)) | (44'd1 << (2 * B));

  always_comb begin
    nxt = in_data;
    if (!in_data.fixed) begin
      if (!in_data.y[ofcw_pkg::XW-1]) begin
        nxt.x = in_data.x + dx;
        nxt.y = in_data.y - dy;
        nxt.z = in_data.z + ofcw_pkg::arc(STEP);
      end else begin
        nxt.x = in_data.x - dx;
        nxt.y = in_data.y + dy;
        nxt.z = in_data.z - ofcw_pkg::arc(STEP);
      end
    end
    if ({1'b0, in_data.rem} >= test) begin
      nxt.rem = in_data.rem - test[ofcw_pkg::REM_BITS-1:0];
      nxt.res = in_data.res | (22'd1 << B);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= nxt;
    end
  end

endmodule

@@ rtl/ofcw_back.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ofcw_back (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  ofcw_pkg::cell_t in_data,
  output logic pixel_valid,
  input  logic pixel_stall,
  output ofcw_pkg::pixel_t pixel
);

  localparam int RB = ofcw_pkg::RAD_BITS;

  logic [3:0] v;
  logic en1, en2, en3, en4;

  logic [29:0] tm;
  logic [5:0] k0;
  logic [15:0] f;
  logic [RB-1:0] rad1, rad2, rad3;
  logic inner1, inner2, inner3;
  logic last1, last2, last3;
  logic [23:0] c2 [3];
  logic [23:0] c3 [3];
  logic [45:0] p3 [3];
  logic [23:0] w0, w1;
  logic [23:0] cn [3];
  logic [7:0] ch [3];
  logic [44:0] diff [3];

  assign en4 = !v[3] || !pixel_stall;
  assign en3 = !v[2] || en4;
  assign en2 = !v[1] || en3;
  assign en1 = !v[0] || en2;
  assign in_ready = en1;
  assign pixel_valid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en1) v[0] <= in_valid;
      if (en2) v[1] <= v[0];
      if (en3) v[2] <= v[1];
      if (en4) v[3] <= v[2];
    end
  end

  // Position on the wheel is t * 54 in Q16 after dropping eight bits.
  assign tm = {in_data.z, 5'd0} + {1'b0, in_data.z, 4'd0} + {3'd0, in_data.z, 2'd0}
            + {4'd0, in_data.z, 1'b0};
  assign w0 = ofcw_pkg::wheel(k0);
  assign w1 = ofcw_pkg::wheel(k0 + 6'd1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cn[i] = 24'(25'(w0[8*i +: 8]) * (25'd65536 - 25'(f)) + 25'(w1[8*i +: 8]) * 25'(f));
      diff[i] = (45'd255 << 37) - 45'(p3[i]);
      ch[i] = inner3 ? diff[i][44:37] : c3[i][23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      k0 <= tm[29:24];
      f <= tm[23:8];
      rad1 <= in_data.res;
      inner1 <= in_data.inner;
      last1 <= in_data.last;
    end
    if (en2) begin
      c2 <= cn;
      rad2 <= rad1;
      inner2 <= inner1;
      last2 <= last1;
    end
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        p3[i] <= 46'(rad2) * 46'((24'd255 << 16) - c2[i]);
      end
      c3 <= c2;
      rad3 <= rad2;
      inner3 <= inner2;
      last3 <= last2;
    end
    if (en4) begin
      pixel.red <= ch[2];
      pixel.green <= ch[1];
      pixel.blue <= ch[0];
      pixel.frame_last_out <= last3;
    end
  end

  `CHECK_NOW(rad_in_disc, clk, rst, v[0] && inner1, rad1 <= (22'd1 << 21))
  `CHECK_NOW(white_at_rest, clk, rst, v[2] && inner3 && rad3 == '0, &{ch[0], ch[1], ch[2]})

endmodule
